// ===== src/spq_pkg.sv =====
// ============================================================================
// spq_pkg: shared definitions for the stable priority queue
// Holds the capacity, field widths, operation and status codes, and the
// command and status groups passed between the controller and the datapath.
// ============================================================================
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // Occupancy reported when an insert is dropped on a full queue.
    localparam logic [OCC_W-1:0] OCC_AT_CAPACITY = OCC_W'(CAPACITY);

    typedef struct packed {
        logic                load;
        logic                ins;
        logic                rem;
        logic [STATUS_W-1:0] status;
    } spq_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } spq_stat_t;

endpackage

// ===== src/spq_if.sv =====
// ============================================================================
// spq_in_if / spq_out_if: valid-ready channels of the priority queue
// The input channel carries one command item; the output channel carries
// the result item that each command produces.
// ============================================================================
interface spq_in_if
    import spq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;

    modport source (output valid, output cmd, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_value, input item_priority,
                    output ready);
endinterface

interface spq_out_if
    import spq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] removed_priority;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input occupancy, output ready);
endinterface

// ===== src/spq_ctrl.sv =====
// ============================================================================
// spq_ctrl: controller of the priority queue
// Accepts command items, decides underflow and overflow, issues the update
// commands to the datapath and tracks whether a result item is pending.
// ============================================================================
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_cmd,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  spq_stat_t stat,
    output spq_ctrl_t ctrl
);

    typedef enum logic {
        S_NO_RESULT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_insert;

    // A new item may enter whenever the result slot is free or is being emptied.
    assign in_ready  = (state_reg == S_NO_RESULT) || out_ready;
    assign out_valid = (state_reg == S_RESULT);
    assign accept    = in_valid && in_ready;
    assign is_insert = (in_cmd == CMD_INSERT);

    always_comb
    begin
        ctrl.load   = accept;
        ctrl.ins    = accept && is_insert && !stat.full;
        ctrl.rem    = accept && !is_insert && !stat.empty;
        ctrl.status = STATUS_OK;
        if (is_insert && stat.full)
        begin
            ctrl.status = STATUS_OVERFLOW;
        end
        else if (!is_insert && stat.empty)
        begin
            ctrl.status = STATUS_UNDERFLOW;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_NO_RESULT:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                end
                else if (out_ready)
                begin
                    state_next = S_NO_RESULT;
                end
            end
            default:
            begin
                state_next = S_NO_RESULT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_NO_RESULT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/spq_dpath.sv =====
// ============================================================================
// spq_dpath: sorted shift-register storage of the priority queue
// Each cell compares its priority with the incoming one in parallel; an
// insert opens a gap at the first larger priority, a remove shifts all
// cells one place toward the front. Also holds the count and result item.
// ============================================================================
module spq_dpath
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic signed [DATA_W-1:0] item_priority,
    output spq_stat_t                stat,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] removed_value,
    output logic signed [DATA_W-1:0] removed_priority,
    output logic [OCC_W-1:0]         occupancy
);

    logic signed [DATA_W-1:0] val_reg [CAPACITY];
    logic signed [DATA_W-1:0] pri_reg [CAPACITY];
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic [CAPACITY-1:0]      le;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [DATA_W-1:0] rv_reg;
    logic signed [DATA_W-1:0] rp_reg;
    logic [OCC_W-1:0]         occ_reg;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == COUNT_W'(CAPACITY));

    // Valid cells whose priority is not above the new one stay in place.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            le[i] = (COUNT_W'(i) < count_reg) && (pri_reg[i] <= item_priority);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (ctrl.ins && !le[i])
            begin
                if (i == 0)
                begin
                    val_reg[i] <= item_value;
                    pri_reg[i] <= item_priority;
                end
                else if (le[(i == 0) ? 0 : i-1])
                begin
                    val_reg[i] <= item_value;
                    pri_reg[i] <= item_priority;
                end
                else
                begin
                    val_reg[i] <= val_reg[(i == 0) ? 0 : i-1];
                    pri_reg[i] <= pri_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if (ctrl.rem && (i < CAPACITY - 1))
            begin
                val_reg[i] <= val_reg[(i < CAPACITY - 1) ? i+1 : i];
                pri_reg[i] <= pri_reg[(i < CAPACITY - 1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            status_reg <= ctrl.status;
            rv_reg     <= ctrl.rem ? val_reg[0] : '0;
            rp_reg     <= ctrl.rem ? pri_reg[0] : '0;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign status           = status_reg;
    assign removed_value    = rv_reg;
    assign removed_priority = rp_reg;
    assign occupancy        = occ_reg;

endmodule

// ===== src/stable_priority_queue.sv =====
// ============================================================================
// stable_priority_queue: sorted-list priority queue with stable ordering
// Top level joining the controller and the shift-register datapath.
// ============================================================================
// The queue holds up to CAPACITY entries (16), each a signed 32-bit value and
// a signed 32-bit priority, kept sorted with the smallest priority at the
// front. An insert item (cmd 0) places the new entry behind every entry whose
// priority is less than or equal to its own, so equal priorities leave in
// arrival order. A remove item (cmd 1) takes out the front entry and returns
// its value and priority. Every item produces exactly one result item with a
// status (ok, underflow on a remove from an empty queue, overflow when an
// insert meets a full queue and is dropped) and the occupancy after the
// operation. An item is executed in the cycle it is accepted: all storage
// cells compare their priorities with the incoming one in parallel and shift
// in one step, and the result is registered, so it appears in the cycle after
// acceptance. The queue takes one item per cycle as long as the result
// register is free or being read in the same cycle; a stalled output holds
// off new items, since the single result register is the only buffer.
// Storage contents are not cleared at reset; only the entry count is.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch
);

    spq_ctrl_t ctrl;
    spq_stat_t stat;

    // Controller: handshakes, underflow and overflow decisions.
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Datapath: sorted cells, entry count and the result register.
    spq_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .item_value       (in_ch.item_value),
        .item_priority    (in_ch.item_priority),
        .stat             (stat),
        .status           (out_ch.status),
        .removed_value    (out_ch.removed_value),
        .removed_priority (out_ch.removed_priority),
        .occupancy        (out_ch.occupancy)
    );

endmodule

// ===== src/spq_checker.sv =====
// ============================================================================
// spq_checker: port-level checks for the stable priority queue
// Watches the channels of the top level and is attached to it by bind.
// ============================================================================
module spq_checker
    import spq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [DATA_W-1:0]   removed_value,
    input logic [DATA_W-1:0]   removed_priority,
    input logic [OCC_W-1:0]    occupancy
);

    // A stalled result item stays offered, with its status, value and occupancy unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(removed_value) && $stable(occupancy))
        else $error("result item changed while stalled");

    // Every accepted item yields its result item in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result item after an accepted item");

    // A remove from an empty queue returns zeros and leaves it empty.
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_UNDERFLOW) |->
            (occupancy == '0) && (removed_value == '0) && (removed_priority == '0))
        else $error("underflow result is not empty");

    // A dropped insert reports a full queue and no removed entry.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OVERFLOW) |->
            (occupancy == OCC_AT_CAPACITY) && (removed_value == '0))
        else $error("overflow result does not report a full queue");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .status           (out_ch.status),
    .removed_value    (out_ch.removed_value),
    .removed_priority (out_ch.removed_priority),
    .occupancy        (out_ch.occupancy)
);

// ===== test/stable_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stable_priority_queue_test: self-checking bench for the stable priority queue
// A directed table of commands runs first. It covers an empty remove, inserts
// up to the full capacity with extreme values and equal priorities, an insert
// that is dropped on a full queue, and removes that drain the front. Random
// fill, drain and mixed phases follow. Every result item is checked, against
// the result typed into its row where the directed row gives one, else against
// a sorted-list model kept inside the bench. Both channels stall at random.
// ============================================================================
module stable_priority_queue_test;
    import spq_pkg::*;

    typedef logic signed [DATA_W-1:0] word_t;

    // One result item, laid out as the output channel carries it.
    typedef struct {
        logic [STATUS_W-1:0] status;
        word_t               value;
        word_t               prio;
        logic [OCC_W-1:0]    occupancy;
    } queue_result_t;

    // One row of the directed table. Where known_result is set, the expected
    // result is the one typed into the row. Otherwise the model supplies it.
    typedef struct {
        logic          cmd;
        word_t         value;
        word_t         prio;
        bit            known_result;
        queue_result_t want;
    } command_row_t;

    localparam word_t PRIO_MIN = 32'sh8000_0000;
    localparam word_t PRIO_MAX = 32'sh7FFF_FFFF;
    localparam int    RANDOM_ITEMS = 1200;
    localparam int    QUIET_TAIL   = 150;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch();
    spq_out_if out_ch();

    stable_priority_queue DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Model of the queue contents. The entries below held_count are kept
    // sorted, front first.
    word_t held_value [CAPACITY];
    word_t held_prio  [CAPACITY];
    int    held_count;

    queue_result_t pending_results[$];
    command_row_t  directed_rows[$];

    int  error_count;
    int  results_checked;
    int  inserts_kept;
    int  inserts_dropped;
    int  removes_served;
    int  removes_empty;
    bit  quiet_tail;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Applies one command to the model queue and returns the result the block
    // must produce. An insert goes behind every entry whose priority is less
    // than or equal to its own. Because of this, equal priorities leave in
    // the order in which they arrived.
    function automatic queue_result_t apply_item(logic cmd, word_t value, word_t prio);
        queue_result_t res;
        int            pos;
        res = '{STATUS_OK, '0, '0, '0};
        if (cmd == CMD_INSERT) begin
            if (held_count >= CAPACITY) begin
                res.status = STATUS_OVERFLOW;
                inserts_dropped++;
            end
            else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio)
                    pos++;
                for (int k = held_count; k > pos; k--) begin
                    held_value[k] = held_value[k-1];
                    held_prio[k]  = held_prio[k-1];
                end
                held_value[pos] = value;
                held_prio[pos]  = prio;
                held_count++;
                inserts_kept++;
            end
        end
        else begin
            if (held_count == 0) begin
                res.status = STATUS_UNDERFLOW;
                removes_empty++;
            end
            else begin
                res.value = held_value[0];
                res.prio  = held_prio[0];
                for (int k = 1; k < held_count; k++) begin
                    held_value[k-1] = held_value[k];
                    held_prio[k-1]  = held_prio[k];
                end
                held_count--;
                removes_served++;
            end
        end
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    // Drive one command item and hold it until the queue takes it. Then
    // record what is expected back. An idle gap may follow, except in the
    // quiet tail of the run. valid stays high when items go back to back.
    task automatic drive_item(input command_row_t row);
        queue_result_t modeled;
        int            gap;
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= row.cmd;
        in_ch.item_value    <= row.value;
        in_ch.item_priority <= row.prio;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        modeled = apply_item(row.cmd, row.value, row.prio);
        pending_results.push_back(row.known_result ? row.want : modeled);
        gap = (!quiet_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_row(input logic cmd, input word_t value, input word_t prio,
                           input bit known, input logic [STATUS_W-1:0] status,
                           input int occupancy);
        command_row_t row;
        row.cmd          = cmd;
        row.value        = value;
        row.prio         = prio;
        row.known_result = known;
        row.want         = '{status, '0, '0, OCC_W'(occupancy)};
        directed_rows.push_back(row);
    endtask

    // Half of the priorities are drawn from a narrow band around zero, so that
    // ties and the ordering of equal priorities get exercised often. The rest
    // are drawn from the full range and from its extremes.
    function automatic word_t random_priority();
        word_t prio;
        case ($urandom_range(0, 5))
            0, 1, 2: prio = word_t'($urandom_range(0, 6)) - 3;
            3:       prio = word_t'($urandom);
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       prio = PRIO_MIN;
                    1:       prio = PRIO_MAX;
                    2:       prio = -1;
                    default: prio = 0;
                endcase
            end
            default: prio = word_t'($urandom);
        endcase
        return prio;
    endfunction

    // Result checker. Each result item taken from the queue must match the
    // oldest expectation, field by field.
    always @(posedge clk)
    begin
        queue_result_t exp_res;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result item with no command outstanding: status %0d occupancy %0d",
                       out_ch.status, out_ch.occupancy);
                error_count++;
            end
            else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (out_ch.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.removed_value !== exp_res.value) begin
                    $error("removed_value: expected %0d, got %0d",
                           exp_res.value, out_ch.removed_value);
                    error_count++;
                end
                if (out_ch.removed_priority !== exp_res.prio) begin
                    $error("removed_priority: expected %0d, got %0d",
                           exp_res.prio, out_ch.removed_priority);
                    error_count++;
                end
                if (out_ch.occupancy !== exp_res.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           exp_res.occupancy, out_ch.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Result consumer. It stalls in random bursts so that a held result
    // item backs up into the input side. In the quiet tail it starts no new stall.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        command_row_t row;
        int           phase;
        int           phase_left;
        int           remove_odds;
        error_count     = 0;
        results_checked = 0;
        inserts_kept    = 0;
        inserts_dropped = 0;
        removes_served  = 0;
        removes_empty   = 0;
        held_count      = 0;
        quiet_tail      = 1'b0;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.cmd           = CMD_INSERT;
        in_ch.item_value    = '0;
        in_ch.item_priority = '0;

        // Directed part. The first removes run on an empty queue. Then
        // sixteen inserts fill the queue with extreme values and several
        // groups of equal priority. One more insert hits the full queue and
        // is dropped. The removes that follow must return the lowest
        // priorities, with equal priorities in arrival order.
        add_row(CMD_REMOVE, 0, 0, 1'b1, STATUS_UNDERFLOW, 0);
        add_row(CMD_REMOVE, 32'shFFFF_FFFF, PRIO_MIN, 1'b1, STATUS_UNDERFLOW, 0);
        add_row(CMD_INSERT, 32'sh7FFF_FFFF, PRIO_MAX, 1'b1, STATUS_OK, 1);
        add_row(CMD_INSERT, 32'sh8000_0000, PRIO_MIN, 1'b1, STATUS_OK, 2);
        add_row(CMD_INSERT, 0, 0, 1'b1, STATUS_OK, 3);
        add_row(CMD_INSERT, -1, -1, 1'b1, STATUS_OK, 4);
        add_row(CMD_INSERT, 1, 0, 1'b1, STATUS_OK, 5);
        add_row(CMD_INSERT, 2, 0, 1'b1, STATUS_OK, 6);
        add_row(CMD_INSERT, 3, PRIO_MIN, 1'b1, STATUS_OK, 7);
        add_row(CMD_INSERT, 4, PRIO_MAX, 1'b1, STATUS_OK, 8);
        add_row(CMD_INSERT, 32'sh5555_5555, 1, 1'b1, STATUS_OK, 9);
        add_row(CMD_INSERT, 32'shAAAA_AAAA, -2, 1'b1, STATUS_OK, 10);
        add_row(CMD_INSERT, 5, 1, 1'b1, STATUS_OK, 11);
        add_row(CMD_INSERT, 6, -2, 1'b1, STATUS_OK, 12);
        add_row(CMD_INSERT, 7, 32'sh4000_0000, 1'b1, STATUS_OK, 13);
        add_row(CMD_INSERT, 8, 32'shC000_0000, 1'b1, STATUS_OK, 14);
        add_row(CMD_INSERT, 9, PRIO_MAX - 1, 1'b1, STATUS_OK, 15);
        add_row(CMD_INSERT, 10, PRIO_MIN + 1, 1'b1, STATUS_OK, 16);
        add_row(CMD_INSERT, 11, PRIO_MIN, 1'b1, STATUS_OVERFLOW, CAPACITY);
        add_row(CMD_REMOVE, 0, 0, 1'b0, STATUS_OK, 0);
        add_row(CMD_REMOVE, 32'sh7FFF_FFFF, PRIO_MAX, 1'b0, STATUS_OK, 0);
        add_row(CMD_REMOVE, 0, 0, 1'b0, STATUS_OK, 0);
        add_row(CMD_REMOVE, 0, 0, 1'b0, STATUS_OK, 0);
        add_row(CMD_REMOVE, 0, 0, 1'b0, STATUS_OK, 0);
        add_row(CMD_REMOVE, 0, 0, 1'b0, STATUS_OK, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_item(directed_rows[i]);

        // Random part. It runs in phases. Fill phases drive the queue into
        // overflow, drain phases empty it into underflow, and mixed phases
        // insert and remove equally often while priorities interleave.
        phase      = 0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 40);
            end
            phase_left--;
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet_tail = 1'b1;
            case (phase)
                0:       remove_odds = 1;
                1:       remove_odds = 7;
                default: remove_odds = 4;
            endcase
            row.cmd          = ($urandom_range(0, 7) < remove_odds) ? CMD_REMOVE : CMD_INSERT;
            row.value        = word_t'($urandom);
            row.prio         = random_priority();
            row.known_result = 1'b0;
            row.want         = '{STATUS_OK, '0, '0, '0};
            drive_item(row);
        end
        in_ch.valid <= 1'b0;

        // Wait until every result item is back, then keep the clock running so
        // that any stray result item would be caught.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d result items: %0d inserts kept, %0d dropped on a full queue,",
                 results_checked, inserts_kept, inserts_dropped);
        $display("%0d removes served, %0d removes on an empty queue.",
                 removes_served, removes_empty);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog. The slowest correct run is about 1250 items and about 0.4 ms
    // long, so this limit leaves a wide margin.
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/spq_pkg.sv
src/spq_if.sv
src/spq_ctrl.sv
src/spq_dpath.sv
src/stable_priority_queue.sv
src/spq_checker.sv
test/stable_priority_queue_test.sv
